// File: rtl/bfiq_pkg.sv
package bfiq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2   = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED_ONE = 64'h243F6A8885A308D3;
  localparam logic [63:0] SEED_TWO = 64'h13198A2E03707344;

  localparam logic [2:0] REG_NUM_BITS   = 3'd0;
  localparam logic [2:0] REG_NUM_HASHES = 3'd4;

  typedef struct packed {
    logic        command;
    logic [63:0] key_word;
    logic [3:0]  word_bytes;
    logic [15:0] key_length;
    logic        last_word;
  } in_t;

  typedef struct packed {
    logic result_kind;
    logic maybe_present;
  } out_t;

  typedef struct packed {
    logic        go;
    logic [64:0] num;
    logic [16:0] den;
  } div_req_t;

endpackage

// File: rtl/bfiq_divmod.sv
module bfiq_divmod (
  input  logic              clk,
  input  logic              rst_n,
  input  bfiq_pkg::div_req_t req,
  output logic              done,
  output logic [16:0]       rem
);
  import bfiq_pkg::*;

  logic [64:0] q_r;
  logic [16:0] rem_r;
  logic [6:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [17:0] sh;
  logic [17:0] sub;

  assign sh   = {rem_r, q_r[64]};
  assign sub  = sh - {1'b0, req.den};
  assign done = done_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        q_r   <= req.num;
        rem_r <= '0;
      end else if (run_r) begin
        q_r   <= {q_r[63:0], 1'b0};
        rem_r <= sub[17] ? sh[16:0] : sub[16:0];
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/bloom_filter_insert_query.sv
// A full non-last word holds busy to be mixed; a short one leaves busy low.
// A last word is hashed (a full one mixed, then finalised), then runs three remainder
// passes, k probes and a drain; with m or k zero the passes and probes are skipped.
// The single-bit store port serialises the probes; the remainder unit is serial.
// The result strobe comes in the same cycle that busy falls.
// Reset: a clearing pass writes every bit of the store to zero with busy high.
module bloom_filter_insert_query #(
  parameter int BIT_CAPACITY = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           start,
  input  bfiq_pkg::in_t  in_data,
  output logic           busy,
  output logic           out_valid,
  output bfiq_pkg::out_t out_data
);
  import bfiq_pkg::*;

  localparam int AW = $clog2(BIT_CAPACITY);
  localparam logic [24:0] CAP_V = 25'(BIT_CAPACITY);
  localparam logic [AW-1:0] CLR_LAST = AW'(BIT_CAPACITY - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]    state_r;
  logic [16:0]   num_bits_r;
  logic [6:0]    num_hashes_r;
  logic [63:0]   h1_r, h2_r, acc_r;
  logic          inside_r, last_r, fin_r, hsel_r, cmd_r;
  logic [3:0]    uop_r;
  logic [1:0]    div_sel_r;
  logic          div_go_r;
  logic [16:0]   x_r, s_r, r64_r, m_r;
  logic [6:0]    cnt_r;
  logic          present_r, rd_pend_r;
  logic [AW-1:0] clr_r;
  logic          out_valid_r;
  out_t          out_r;

  logic          mem [BIT_CAPACITY];
  logic          mem_q;
  logic          mem_we, mem_wd;
  logic [AW-1:0] mem_wa;

  logic          acc_in, cfg_we;
  logic [3:0]    nb;
  logic [63:0]   tail, seed_add, base1, base2;
  logic [16:0]   m_eff;
  logic [63:0]   cur, nv, cst, step;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [1:0]    phase;
  logic [3:0]    uend;
  logic [64:0]   sum65;
  logic [17:0]   t, d;
  logic [16:0]   t1, xn;
  logic          pres_fin;
  div_req_t      dreq;
  logic          div_done;
  logic [16:0]   div_rem;

  assign pready    = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign acc_in    = start && (state_r == S_IDLE);
  assign cfg_we    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_NUM_HASHES[2]) ? {25'd0, num_hashes_r}
                                                     : {15'd0, num_bits_r};

  assign nb = (in_data.word_bytes > 4'd8) ? 4'd8 : in_data.word_bytes;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail[8*b +: 8] = (4'(b) < nb) ? in_data.key_word[8*b +: 8] : 8'd0;
    end
  end
  assign seed_add = GOLDEN + 64'(in_data.key_length);
  assign base1    = inside_r ? h1_r : (SEED_ONE ^ seed_add);
  assign base2    = inside_r ? h2_r : (SEED_TWO ^ seed_add);

  assign m_eff = (25'(num_bits_r) > CAP_V) ? 17'(CAP_V) : num_bits_r;

  assign cur   = hsel_r ? h2_r : h1_r;
  assign cst   = (uop_r < 4'd4) ? MIX_C1 : MIX_C2;
  assign uend  = fin_r ? 4'd8 : 4'd7;
  always_comb begin
    case (uop_r)
      4'd1, 4'd5: phase = 2'd0;
      4'd2, 4'd6: phase = 2'd1;
      default:    phase = 2'd2;
    endcase
  end
  assign mul_a = (phase == 2'd2) ? cur[63:32] : cur[31:0];
  assign mul_b = (phase == 2'd1) ? cst[63:32] : cst[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    case (uop_r)
      4'd0:       nv = cur ^ (cur >> 30);
      4'd4:       nv = cur ^ (cur >> 27);
      4'd8:       nv = cur ^ (cur >> 31);
      4'd3, 4'd7: nv = acc_r + {prod[31:0], 32'd0};
      default:    nv = cur;
    endcase
  end

  assign step = {h2_r[62:0], 1'b1};
  always_comb begin
    case (div_sel_r)
      2'd0:    dreq.num = {1'b0, h1_r};
      2'd1:    dreq.num = {1'b0, step};
      default: dreq.num = {1'b1, 64'd0};
    endcase
  end
  assign dreq.go  = div_go_r;
  assign dreq.den = m_r;

  bfiq_divmod u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (div_done),
    .rem  (div_rem)
  );

  assign sum65 = {1'b0, 47'd0, x_r} + {1'b0, step};
  assign t     = {1'b0, x_r} + {1'b0, s_r};
  assign t1    = (t >= {1'b0, m_r}) ? 17'(t - {1'b0, m_r}) : t[16:0];
  assign d     = {1'b0, t1} - {1'b0, r64_r};
  assign xn    = !sum65[64] ? t1 : (d[17] ? 17'(d + {1'b0, m_r}) : d[16:0]);

  assign pres_fin = present_r && !(rd_pend_r && !mem_q);

  assign mem_we = (state_r == S_CLEAR) || (state_r == S_PROBE && cmd_r == CMD_INSERT);
  assign mem_wa = (state_r == S_CLEAR) ? clr_r : AW'(x_r);
  assign mem_wd = (state_r != S_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[AW'(x_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      num_bits_r   <= 17'd1024;
      num_hashes_r <= 7'd7;
      inside_r     <= 1'b0;
      h1_r         <= '0;
      h2_r         <= '0;
      clr_r        <= '0;
      div_go_r     <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      fin_r        <= 1'b0;
      hsel_r       <= 1'b0;
      uop_r        <= '0;
      cnt_r        <= '0;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= (state_r == S_PROBE) && (cmd_r == CMD_QUERY);
      if (rd_pend_r && !mem_q) begin
        present_r <= 1'b0;
      end
      if (cfg_we) begin
        if (paddr == REG_NUM_BITS) begin
          num_bits_r <= pwdata[16:0];
        end else if (paddr == REG_NUM_HASHES) begin
          num_hashes_r <= pwdata[6:0];
        end
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc_in) begin
            cmd_r    <= in_data.command;
            last_r   <= in_data.last_word;
            inside_r <= !in_data.last_word;
            hsel_r   <= 1'b0;
            uop_r    <= '0;
            if (nb == 4'd8) begin
              h1_r    <= base1 + in_data.key_word + GOLDEN;
              h2_r    <= base2 + in_data.key_word + GOLDEN;
              fin_r   <= 1'b0;
              state_r <= S_HASH;
            end else begin
              h1_r  <= base1 + tail;
              h2_r  <= base2 + tail;
              fin_r <= 1'b1;
              if (in_data.last_word) begin
                state_r <= S_HASH;
              end
            end
          end
        end
        S_HASH: begin
          if (phase == 2'd0 && uop_r != 4'd0 && uop_r != 4'd4 && uop_r != 4'd8) begin
            acc_r <= prod;
          end else if (phase == 2'd1) begin
            acc_r <= acc_r + {prod[31:0], 32'd0};
          end
          if (hsel_r) begin
            h2_r <= nv;
          end else begin
            h1_r <= nv;
          end
          if (uop_r == uend) begin
            uop_r  <= '0;
            hsel_r <= !hsel_r;
            if (hsel_r) begin
              if (!fin_r) begin
                if (last_r) begin
                  fin_r <= 1'b1;
                end else begin
                  state_r <= S_IDLE;
                end
              end else begin
                m_r       <= m_eff;
                div_sel_r <= 2'd0;
                if (m_eff == 17'd0) begin
                  present_r <= 1'b0;
                  state_r   <= S_DRAIN;
                end else if (num_hashes_r == 7'd0) begin
                  present_r <= 1'b1;
                  state_r   <= S_DRAIN;
                end else begin
                  present_r <= 1'b1;
                  div_go_r  <= 1'b1;
                  state_r   <= S_DIV;
                end
              end
            end
          end else begin
            uop_r <= uop_r + 4'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (div_sel_r)
              2'd0: begin
                x_r       <= div_rem;
                div_sel_r <= 2'd1;
                div_go_r  <= 1'b1;
              end
              2'd1: begin
                s_r       <= div_rem;
                div_sel_r <= 2'd2;
                div_go_r  <= 1'b1;
              end
              default: begin
                r64_r   <= div_rem;
                cnt_r   <= '0;
                state_r <= S_PROBE;
              end
            endcase
          end
        end
        S_PROBE: begin
          x_r   <= xn;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == num_hashes_r - 7'd1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          out_valid_r           <= 1'b1;
          out_r.result_kind     <= cmd_r;
          out_r.maybe_present   <= (cmd_r == CMD_QUERY) && pres_fin;
          state_r               <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: bench/bloom_filter_insert_query_test.sv
`timescale 1ns / 1ps

module bloom_filter_insert_query_test;
  import bfiq_pkg::*;

  class bloom_scoreboard;
    bit          filter_bits [65536];
    logic [63:0] acc_one;
    logic [63:0] acc_two;
    bit          mid_key;
    logic [16:0] size_m;
    logic [6:0]  probes_k;
    out_t        answers [$];
    int          errors;

    function new();
      size_m = 17'd1024;
      probes_k = 7'd7;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == REG_NUM_BITS) size_m = value[16:0];
      else if (addr == REG_NUM_HASHES) probes_k = value[6:0];
    endfunction

    function logic [63:0] churn(logic [63:0] x);
      x = x ^ (x >> 30);
      x = x * MIX_C1;
      x = x ^ (x >> 27);
      x = x * MIX_C2;
      return x;
    endfunction

    function void note(in_t w);
      logic [3:0]  nb;
      logic [63:0] tail, f1, f2, stride, pos, m;
      bit          hit;
      out_t        o;
      nb = (w.word_bytes > 4'd8) ? 4'd8 : w.word_bytes;
      if (!mid_key) begin
        acc_one = SEED_ONE ^ (GOLDEN + 64'(w.key_length));
        acc_two = SEED_TWO ^ (GOLDEN + 64'(w.key_length));
        mid_key = 1;
      end
      if (nb == 4'd8) begin
        acc_one = churn(acc_one + w.key_word + GOLDEN);
        acc_two = churn(acc_two + w.key_word + GOLDEN);
      end else begin
        tail = (nb == 0) ? 64'd0 : w.key_word & ((64'd1 << (8 * nb)) - 64'd1);
        acc_one += tail;
        acc_two += tail;
      end
      if (!w.last_word) return;
      mid_key = 0;
      f1 = churn(acc_one);
      f1 = f1 ^ (f1 >> 31);
      f2 = churn(acc_two);
      f2 = f2 ^ (f2 >> 31);
      stride = {f2[62:0], 1'b1};
      m = (size_m > 17'd65536) ? 64'd65536 : 64'(size_m);
      hit = 1;
      if (m == 0) begin
        hit = 0;
      end else begin
        pos = f1 % m;
        for (int i = 0; i < probes_k; i++) begin
          if (w.command == CMD_INSERT) filter_bits[pos] = 1;
          else if (!filter_bits[pos]) hit = 0;
          pos = (pos + stride) % m;
        end
      end
      o.result_kind = w.command;
      o.maybe_present = (w.command == CMD_QUERY) && hit;
      answers.push_back(o);
    endfunction

    function void check(out_t got);
      out_t want;
      if (answers.size() == 0) begin
        $error("unexpected result kind=%0d present=%0d", got.result_kind, got.maybe_present);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind expected %0d got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.maybe_present !== want.maybe_present) begin
        $error("maybe_present expected %0d got %0d", want.maybe_present, got.maybe_present);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    logic [63:0] w [4];
    int          len;
    logic [15:0] klen;
  } key_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 0;
  in_t         in_data = '0;
  logic        busy, out_valid;
  out_t        out_data;

  bloom_scoreboard board = new();
  key_t        known_keys [$];
  int          gap_pct = 0;
  int          sent = 0;

  bloom_filter_insert_query dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (rst_n && out_valid) board.check(out_data);
  end

  task automatic push_word(in_t w);
    bit taken;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_data <= w;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    board.note(w);
    sent++;
  endtask

  task automatic settle();
    start <= 0;
    while (board.answers.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    board.set_reg(addr, value);
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] bits_m, logic [31:0] probes);
    settle();
    write_reg(REG_NUM_BITS, bits_m);
    write_reg(REG_NUM_HASHES, probes);
  endtask

  task automatic send_key(key_t k, logic cmd);
    int   nw, left;
    in_t  w;
    nw = (k.len + 7) / 8;
    if (nw == 0) nw = 1;
    for (int i = 0; i < nw; i++) begin
      left = k.len - 8 * i;
      w.command = cmd;
      w.key_word = k.w[i];
      w.word_bytes = (left > 8) ? 4'd8 : 4'(left);
      w.key_length = k.klen;
      w.last_word = (i == nw - 1);
      push_word(w);
    end
  endtask

  function automatic key_t fresh_key(int len);
    key_t k;
    for (int i = 0; i < 4; i++) k.w[i] = {$urandom(), $urandom()};
    k.len = len;
    k.klen = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'(len);
    return k;
  endfunction

  task automatic send_noise();
    in_t w;
    int  n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      w.command = 1'($urandom());
      w.key_word = {$urandom(), $urandom()};
      w.word_bytes = 4'($urandom_range(15));
      w.key_length = 16'($urandom());
      w.last_word = (i == n - 1);
      push_word(w);
    end
  endtask

  task automatic random_traffic(int count);
    key_t k;
    int   stop, r;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 35) begin
        k = fresh_key($urandom_range(0, 32));
        send_key(k, CMD_INSERT);
        if (known_keys.size() > 200) void'(known_keys.pop_front());
        known_keys.push_back(k);
      end else if (r < 60 && known_keys.size() > 0) begin
        send_key(known_keys[$urandom_range(known_keys.size() - 1)], CMD_QUERY);
      end else if (r < 80) begin
        send_key(fresh_key($urandom_range(0, 32)), 1'($urandom()));
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic directed();
    key_t k;
    in_t  w;
    k = fresh_key(0);
    k.klen = 0;
    send_key(k, CMD_INSERT);
    send_key(k, CMD_QUERY);
    k = fresh_key(8);
    k.w[0] = '1;
    k.klen = 16'hFFFF;
    send_key(k, CMD_INSERT);
    send_key(k, CMD_QUERY);
    k.w[0] = '0;
    send_key(k, CMD_QUERY);
    k = fresh_key(19);
    send_key(k, CMD_INSERT);
    send_key(k, CMD_QUERY);
    w.command = CMD_QUERY;
    w.key_word = '1;
    w.word_bytes = 4'd15;
    w.key_length = 16'd3;
    w.last_word = 0;
    push_word(w);
    w.word_bytes = 4'd3;
    push_word(w);
    w.word_bytes = 4'd9;
    w.last_word = 1;
    push_word(w);
  endtask

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    configure(32'd1, 32'd1);
    directed();
    configure(32'd0, 32'd5);
    directed();
    configure(32'hFFFF_FFFF, 32'd0);
    directed();
    configure(32'd65536, 32'd64);
    for (int seg = 0; seg < 6; seg++) begin
      case (seg % 4)
        0: gap_pct = 0;
        1: gap_pct = 64;
        2: gap_pct = 0;
        default: gap_pct = 21;
      endcase
      case (seg)
        0: configure(32'd65536, 32'd64);
        1: configure(32'd1024, 32'd7);
        2: configure(32'd97, 32'd3);
        3: configure(32'd0, 32'd127);
        4: configure(32'd131071, 32'd1);
        default: configure($urandom_range(1, 65536), $urandom_range(0, 127));
      endcase
      random_traffic(240);
    end
    settle();
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/bfiq_pkg.sv
rtl/bfiq_divmod.sv
rtl/bloom_filter_insert_query.sv
bench/bloom_filter_insert_query_test.sv
